// ===== rtl/vertex_transform_4x4_assert.svh =====
// ----------------------------------------------------------------------------
// vertex_transform_4x4 assertion macros
// Shared property shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_4X4_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_ASSERT_SVH

// same-cycle implication
`define VT4_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vt4 assertion failed");

// next-cycle implication
`define VT4_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vt4 assertion failed");

`endif

// ===== rtl/vt4_pkg.sv =====
// ----------------------------------------------------------------------------
// vt4_pkg
// Types, widths and helpers shared by the 4x4 vertex transform pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vt4_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int LANES     = 4;
	localparam int IDX_W     = $clog2(LANES);
	localparam int ACC_W     = PROD_W + IDX_W;

	typedef logic signed [DATA_W-1:0] vt4_word_t;
	typedef logic signed [PROD_W-1:0] vt4_prod_t;
	typedef logic signed [ACC_W-1:0]  vt4_acc_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_VEC4  = 2'd1,
		OP_POINT = 2'd2,
		OP_DIR   = 2'd3
	} vt4_op_t;

	localparam vt4_word_t ONE_Q = DATA_W'(64'd1 << FRAC_BITS);

	typedef struct packed {
		vt4_op_t              opcode;
		logic [2*IDX_W-1:0]   elem_index;
		vt4_word_t            elem_value;
		vt4_word_t            in_x;
		vt4_word_t            in_y;
		vt4_word_t            in_z;
		vt4_word_t            in_w;
	} vt4_in_t;

	typedef struct packed {
		vt4_word_t out_x;
		vt4_word_t out_y;
		vt4_word_t out_z;
		vt4_word_t out_w;
		logic      sat_flag;
	} vt4_out_t;

	// request as it travels down the cell chain, with running column sums
	typedef struct packed {
		vt4_op_t                     opcode;
		logic [2*IDX_W-1:0]          elem_index;
		vt4_word_t                   elem_value;
		vt4_word_t [LANES-1:0]       vec;
		vt4_acc_t  [LANES-1:0]       acc;
	} vt4_item_t;

	function automatic vt4_word_t ident_elem(input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col);
		return (row == col) ? ONE_Q : '0;
	endfunction

endpackage

// ===== rtl/vt4_cell.sv =====
// ----------------------------------------------------------------------------
// vt4_cell
// One matrix row: multiplies its vector component by the row and adds the
// four products into the running column sums. Loads for this row land here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vt4_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [vt4_pkg::IDX_W-1:0]         row_idx,
	input  logic                              up_valid,
	output logic                              up_ready,
	input  vt4_pkg::vt4_item_t                up,
	output logic                              dn_valid,
	input  logic                              dn_ready,
	output vt4_pkg::vt4_item_t                dn
);
	import vt4_pkg::*;

	// stored XORed with identity so reset is all zeros
	vt4_word_t [LANES-1:0] row_q;
	vt4_word_t [LANES-1:0] elem;
	vt4_prod_t [LANES-1:0] mul;
	vt4_prod_t [LANES-1:0] prod_s1;
	vt4_item_t             item_s1;
	vt4_item_t             item_s2;
	vt4_item_t             sum_nxt;
	logic                  vld_s1;
	logic                  vld_s2;
	logic                  adv1;
	logic                  adv2;
	logic                  take;
	logic                  wr_hit;
	vt4_word_t             vsel;

	always_comb begin
		vsel = $signed(up.vec[row_idx]);
		for (int j = 0; j < LANES; j++) begin
			elem[j] = row_q[j] ^ ident_elem(row_idx, IDX_W'(j));
			mul[j]  = $signed(vsel) * $signed(elem[j]);
		end
	end

	always_comb begin
		sum_nxt = item_s1;
		for (int j = 0; j < LANES; j++) begin
			sum_nxt.acc[j] = $signed(item_s1.acc[j]) + ACC_W'($signed(prod_s1[j]));
		end
	end

	assign adv2     = !vld_s2 || dn_ready;
	assign adv1     = !vld_s1 || adv2;
	assign up_ready = adv1;
	assign take     = up_valid && adv1;
	assign wr_hit   = take && (up.opcode == OP_LOAD) &&
		(up.elem_index[2*IDX_W-1:IDX_W] == row_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (wr_hit) begin
				row_q[up.elem_index[IDX_W-1:0]] <= up.elem_value ^
					ident_elem(row_idx, up.elem_index[IDX_W-1:0]);
			end
			if (adv1) begin
				vld_s1 <= up_valid;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= up;
			prod_s1 <= mul;
		end
		if (adv2 && vld_s1) begin
			item_s2 <= sum_nxt;
		end
	end

	assign dn_valid = vld_s2;
	assign dn       = item_s2;

endmodule

// ===== rtl/vt4_out.sv =====
// ----------------------------------------------------------------------------
// vt4_out
// Scales the column sums back to Q16.16, saturates, and holds the result.
// Load requests are consumed here without producing a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vt4_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  vt4_pkg::vt4_item_t   up,
	output logic                 res_valid,
	input  logic                 res_ready,
	output vt4_pkg::vt4_out_t    res
);
	import vt4_pkg::*;

	vt4_acc_t              sh [LANES];
	vt4_word_t [LANES-1:0] val;
	logic [LANES-1:0]      sat;
	logic [LANES-1:0]      used;
	logic                  fits;
	logic                  vld_q;
	vt4_out_t              res_q;
	vt4_out_t              nxt;

	always_comb begin
		fits = 1'b1;
		for (int j = 0; j < LANES; j++) begin
			sh[j]  = $signed(up.acc[j]) >>> FRAC_BITS;
			fits   = (&sh[j][ACC_W-1:DATA_W-1]) || !(|sh[j][ACC_W-1:DATA_W-1]);
			sat[j] = !fits;
			if (fits) begin
				val[j] = sh[j][DATA_W-1:0];
			end else if (sh[j][ACC_W-1]) begin
				val[j] = {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				val[j] = {1'b0, {(DATA_W-1){1'b1}}};
			end
			used[j] = (j < LANES - 1) || (up.opcode == OP_VEC4);
		end
		nxt.out_x    = val[0];
		nxt.out_y    = val[1];
		nxt.out_z    = val[2];
		nxt.out_w    = (up.opcode == OP_VEC4) ? val[3] : '0;
		nxt.sat_flag = |(sat & used);
	end

	assign up_ready = !vld_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid && (up.opcode != OP_LOAD);
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			res_q <= nxt;
		end
	end

	assign res_valid = vld_q;
	assign res       = res_q;

endmodule

// ===== rtl/vertex_transform_4x4.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// Row vector times 4x4 Q16.16 matrix, built as a chain of four row cells.
// ----------------------------------------------------------------------------
// Input channel vtx_valid/vtx_ready/vtx carries one request: a matrix element
// load (opcode 0) or a transform of a vec4, point (w = 1) or direction (w = 0).
// Output channel res_valid/res_ready/res carries one result per transform;
// loads give none. Results leave in request order.
// Each of the four cells holds one matrix row and handles a request in a
// multiply stage, then an add stage into the column sums; a final stage shifts
// and saturates. One request is taken every cycle while the output is drained.
// A load updates its row as it passes that row's cell, so it only affects
// requests behind it.
// Reset puts the matrix back to identity and empties the pipeline.
// When res_ready is low the result holds and the chain keeps filling its
// empty stages; vtx_ready drops only once every stage is occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_transform_4x4 (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vtx_valid,
	output logic                vtx_ready,
	input  vt4_pkg::vt4_in_t    vtx,
	output logic                res_valid,
	input  logic                res_ready,
	output vt4_pkg::vt4_out_t   res
);
	import vt4_pkg::*;

	logic      [LANES:0] vld;
	logic      [LANES:0] rdy;
	vt4_item_t           itm [LANES+1];

	always_comb begin
		itm[0].opcode     = vtx.opcode;
		itm[0].elem_index = vtx.elem_index;
		itm[0].elem_value = vtx.elem_value;
		itm[0].vec[0]     = vtx.in_x;
		itm[0].vec[1]     = vtx.in_y;
		itm[0].vec[2]     = vtx.in_z;
		unique case (vtx.opcode)
			OP_VEC4:  itm[0].vec[3] = vtx.in_w;
			OP_POINT: itm[0].vec[3] = ONE_Q;
			default:  itm[0].vec[3] = '0;
		endcase
		itm[0].acc = '0;
	end

	assign vld[0]    = vtx_valid;
	assign vtx_ready = rdy[0];

	for (genvar g = 0; g < LANES; g++) begin : g_cell
		vt4_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.row_idx  (IDX_W'(g)),
			.up_valid (vld[g]),
			.up_ready (rdy[g]),
			.up       (itm[g]),
			.dn_valid (vld[g+1]),
			.dn_ready (rdy[g+1]),
			.dn       (itm[g+1])
		);
	end

	vt4_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (vld[LANES]),
		.up_ready  (rdy[LANES]),
		.up        (itm[LANES]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

// ===== rtl/vt4_checker.sv =====
// ----------------------------------------------------------------------------
// vt4_checker
// Port-level checks for the vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vertex_transform_4x4_assert.svh"

module vt4_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vtx_ready,
	input  logic                res_valid,
	input  logic                res_ready,
	input  vt4_pkg::vt4_out_t   res
);
	import vt4_pkg::*;

	logic at_rail;

	assign at_rail =
		res.out_x == 32'sh7fffffff || res.out_x == 32'sh80000000 ||
		res.out_y == 32'sh7fffffff || res.out_y == 32'sh80000000 ||
		res.out_z == 32'sh7fffffff || res.out_z == 32'sh80000000 ||
		res.out_w == 32'sh7fffffff || res.out_w == 32'sh80000000;

	// a stalled result holds
	`VT4_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

	// an output stage that drains leaves the whole chain ready
	`VT4_ASSERT_SAME(a_ready_chain, !res_valid || res_ready, vtx_ready)

	// a saturation flag means some component sits at a rail
	`VT4_ASSERT_SAME(a_sat_rail, res_valid && res.sat_flag, at_rail)

endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (.*);
